[rtl/core/mlpq_pkg.sv]
// Package for the multi-level priority queue: payload structs, status and
// operation codes, default sizes, and the controller/datapath link types.
// Used by every module under rtl/core except mlpq_ram; depends on nothing.
package mlpq_pkg;

    localparam int LEVELS_DEF     = 8;
    localparam int DEPTH_DEF      = 8;
    localparam int DATA_WIDTH_DEF = 16;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DELETE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_INVALID   = 2'd3
    } status_t;

    typedef struct packed {
        logic               operation;
        logic signed [15:0] value;
        logic [3:0]         priority_req;
    } req_t;

    typedef struct packed {
        status_t            status;
        logic signed [15:0] popped_value;
        logic [3:0]         popped_level;
    } rsp_t;

    // controller -> datapath
    typedef struct packed {
        logic load_item;
        logic exec;
        logic capture_read;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic need_read;
    } stat_t;

endpackage

[rtl/core/multi_level_priority_queue.sv]
// Channel  | Handshake             | Beat   | Direction
// request  | req_valid / req_stall | req    | into the block
// response | rsp_valid / rsp_stall | rsp    | out of the block
//
// One request at a time. An insert or a failed operation passes through S_EXEC
// to the response in S_OUT; a successful delete also passes S_READ, for the
// registered read of the single-port entry RAM. The next request is taken the
// cycle after the response beat; rsp_stall holds the response until it is taken.
// Reset clears head, tail and count of every level at once; no clearing pass.
// Entry storage is not reset. Depends on mlpq_pkg, mlpq_ctrl, mlpq_dp, mlpq_ram.
module multi_level_priority_queue #(
    parameter int LEVELS     = mlpq_pkg::LEVELS_DEF,
    parameter int DEPTH      = mlpq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = mlpq_pkg::DATA_WIDTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  mlpq_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output mlpq_pkg::rsp_t rsp
);

    mlpq_pkg::cmd_t  cmd;
    mlpq_pkg::stat_t stat;

    mlpq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

    mlpq_dp #(
        .LEVELS     (LEVELS),
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cmd   (cmd),
        .stat  (stat)
    );

endmodule

[rtl/core/mlpq_ram.sv]
// Generic single-port RAM with registered read for the priority queue.
// No dependencies.
module mlpq_ram #(
    parameter int WIDTH = 16,
    parameter int WORDS = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic                     rd_en,
    input  logic [$clog2(WORDS)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [WORDS];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wdata;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/mlpq_ctrl.sv]
// Sequencing controller for the priority queue: accept, execute, read, present.
// Depends on mlpq_pkg.
module mlpq_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output mlpq_pkg::cmd_t cmd,
    input  mlpq_pkg::stat_t stat
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_READ = 4'b0100,
        S_OUT  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next       = state_reg;
        cmd.load_item    = 1'b0;
        cmd.exec         = 1'b0;
        cmd.capture_read = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = stat.need_read ? S_READ : S_OUT;
            end
            S_READ:
            begin
                cmd.capture_read = 1'b1;
                state_next       = S_OUT;
            end
            S_OUT:
            begin
                if (!rsp_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = (state_reg == S_OUT);

endmodule

[rtl/core/mlpq_dp.sv]
// Datapath of the priority queue: per-level head/tail/count registers, level
// priority encoder, entry RAM and result register. Depends on mlpq_pkg, mlpq_ram.
module mlpq_dp #(
    parameter int LEVELS     = mlpq_pkg::LEVELS_DEF,
    parameter int DEPTH      = mlpq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = mlpq_pkg::DATA_WIDTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  mlpq_pkg::req_t  req,
    output mlpq_pkg::rsp_t  rsp,
    input  mlpq_pkg::cmd_t  cmd,
    output mlpq_pkg::stat_t stat
);

    localparam int LVL_W  = $clog2(LEVELS);
    localparam int SLOT_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int WORDS  = LEVELS * DEPTH;
    localparam int ADDR_W = $clog2(WORDS);
    localparam logic [3:0] LEVELS_4 = 4'(LEVELS);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(DEPTH);

    mlpq_pkg::req_t item_reg;
    mlpq_pkg::rsp_t rsp_reg;

    logic [SLOT_W-1:0] head_reg  [LEVELS];
    logic [SLOT_W-1:0] tail_reg  [LEVELS];
    logic [CNT_W-1:0]  count_reg [LEVELS];

    logic              is_insert;
    logic              prio_bad;
    logic [3:0]        prio_m1;
    logic              any_busy;
    logic [LVL_W-1:0]  top_lvl;
    logic [LVL_W-1:0]  lvl_sel;
    logic              lvl_full;
    logic              ins_ok;
    logic              del_ok;
    logic [SLOT_W-1:0] slot_sel;
    logic [ADDR_W-1:0] ram_addr;
    logic [31:0]       value_ext;
    logic [DATA_WIDTH-1:0] ram_wdata;
    logic [DATA_WIDTH-1:0] ram_rdata;
    logic [31:0]       rdata_ext;
    mlpq_pkg::status_t status_sel;

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg <= req;
        end
    end

    // Highest priority non-empty level: lowest index wins.
    always_comb
    begin
        any_busy = 1'b0;
        top_lvl  = '0;
        for (int i = LEVELS - 1; i >= 0; i--)
        begin
            if (count_reg[i] != '0)
            begin
                any_busy = 1'b1;
                top_lvl  = LVL_W'(i);
            end
        end
    end

    assign is_insert = (item_reg.operation == mlpq_pkg::OP_INSERT);
    assign prio_bad  = (item_reg.priority_req == 4'd0) || (item_reg.priority_req > LEVELS_4);
    assign prio_m1   = item_reg.priority_req - 4'd1;
    assign lvl_sel   = is_insert ? prio_m1[LVL_W-1:0] : top_lvl;
    assign lvl_full  = (count_reg[lvl_sel] == CNT_FULL);
    assign ins_ok    = is_insert && !prio_bad && !lvl_full;
    assign del_ok    = !is_insert && any_busy;
    assign slot_sel  = is_insert ? tail_reg[lvl_sel] : head_reg[lvl_sel];
    assign ram_addr  = ADDR_W'(int'(lvl_sel) * DEPTH + int'(slot_sel));

    always_comb
    begin
        if (is_insert)
        begin
            if (prio_bad)
            begin
                status_sel = mlpq_pkg::ST_INVALID;
            end
            else if (lvl_full)
            begin
                status_sel = mlpq_pkg::ST_OVERFLOW;
            end
            else
            begin
                status_sel = mlpq_pkg::ST_OK;
            end
        end
        else
        begin
            status_sel = any_busy ? mlpq_pkg::ST_OK : mlpq_pkg::ST_UNDERFLOW;
        end
    end

    // Sign-extend the 16-bit input, keep DATA_WIDTH bits; reverse on the way out.
    assign value_ext = 32'(item_reg.value);
    assign ram_wdata = value_ext[DATA_WIDTH-1:0];
    assign rdata_ext = 32'($signed(ram_rdata));

    mlpq_ram #(
        .WIDTH (DATA_WIDTH),
        .WORDS (WORDS)
    ) u_ram (
        .clk   (clk),
        .wr_en (cmd.exec && ins_ok),
        .rd_en (cmd.exec && del_ok),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LEVELS; i++)
            begin
                head_reg[i]  <= '0;
                tail_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
        end
        else if (cmd.exec)
        begin
            if (ins_ok)
            begin
                tail_reg[lvl_sel]  <= (slot_sel == SLOT_LAST) ? '0 : slot_sel + 1'b1;
                count_reg[lvl_sel] <= count_reg[lvl_sel] + 1'b1;
            end
            else if (del_ok)
            begin
                head_reg[lvl_sel]  <= (slot_sel == SLOT_LAST) ? '0 : slot_sel + 1'b1;
                count_reg[lvl_sel] <= count_reg[lvl_sel] - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            rsp_reg.status       <= status_sel;
            rsp_reg.popped_value <= '0;
            rsp_reg.popped_level <= del_ok ? 4'(int'(lvl_sel) + 1) : 4'd0;
        end
        else if (cmd.capture_read)
        begin
            rsp_reg.popped_value <= rdata_ext[15:0];
        end
    end

    assign rsp            = rsp_reg;
    assign stat.need_read = del_ok;

endmodule

[rtl/core/mlpq_checker.sv]
// Port-level checks for the priority queue, bound to the top level.
// Depends on mlpq_pkg and multi_level_priority_queue.
module mlpq_checker #(
    parameter int LEVELS = mlpq_pkg::LEVELS_DEF
) (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_stall,
    input logic           rsp_valid,
    input logic           rsp_stall,
    input mlpq_pkg::rsp_t rsp
);

    localparam logic [3:0] LEVELS_4 = 4'(LEVELS);

    // Hold a stalled response beat.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("response beat changed while stalled");

    // Take no new request while a response is pending.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> req_stall)
        else $error("request taken while response pending");

    // An accepted request cannot be answered in the next cycle.
    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> !rsp_valid && req_stall)
        else $error("response too early or request overlap");

    // Failed operations pop nothing.
    a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status != mlpq_pkg::ST_OK |->
            rsp.popped_value == 16'sd0 && rsp.popped_level == 4'd0)
        else $error("failed operation carries popped data");

    // Popped level stays within the configured levels.
    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.popped_level <= LEVELS_4)
        else $error("popped level out of range");

endmodule

bind multi_level_priority_queue mlpq_checker #(.LEVELS(LEVELS)) u_mlpq_checker (.*);
